// ===== hw/rtl/command_frame_decimal_parser_assert.svh =====
// Assertion macros used by the command frame decimal parser top level.
`ifndef COMMAND_FRAME_DECIMAL_PARSER_ASSERT_SVH
`define COMMAND_FRAME_DECIMAL_PARSER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define CFDP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfdp assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define CFDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfdp assertion failed");

`endif

// ===== hw/rtl/cfdp_pkg.sv =====
// Package with constants, types and helper functions of the frame parser.
`timescale 1ns / 1ps
package cfdp_pkg;

  localparam int MATCH_BYTES     = 8;
  localparam int FRACTION_DIGITS = 3;
  localparam int VALUE_BITS      = 32;

  localparam int CFG_W  = 64;
  localparam int MAG_W  = VALUE_BITS - 1;
  localparam int W10_W  = 24;
  localparam int SUM_W  = ((MAG_W + 4) > (W10_W + 4) ? (MAG_W + 4) : (W10_W + 4)) + 1;
  localparam int FC_W   = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
  localparam int IDX_W  = (MATCH_BYTES > 1) ? $clog2(MATCH_BYTES) : 1;

  localparam logic [3:0] MATCH_LEN = 4'(MATCH_BYTES);

  // Characters of interest.
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Event kinds.
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_TOGGLE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_VALUE_PREFIX       = 2'd0;
  localparam logic [1:0] REG_VALUE_PREFIX_LEN   = 2'd1;
  localparam logic [1:0] REG_TOGGLE_COMMAND     = 2'd2;
  localparam logic [1:0] REG_TOGGLE_COMMAND_LEN = 2'd3;

  // Most negative value, never produced by a saturated magnitude.
  localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // One byte moving through the parse stage.
  typedef struct packed {
    logic       fire;
    logic       last;
    logic [7:0] data;
  } step_t;

  // Match results for the byte being processed.
  typedef struct packed {
    logic parse_en;
    logic value_ok;
    logic toggle_ok;
  } match_t;

  // Number state after the byte being processed.
  typedef struct packed {
    logic             digit_seen;
    logic             negative;
    logic [MAG_W-1:0] magnitude;
  } parse_t;

  // Power of ten for a small exponent.
  function automatic logic [W10_W-1:0] pow10(input int n);
    logic [W10_W-1:0] r;
    r = W10_W'(1);
    for (int i = 0; i < 6; i++) begin
      if (i < n) begin
        r = W10_W'(r * W10_W'(10));
      end
    end
    return r;
  endfunction

  // A length above the match width counts as the match width.
  function automatic logic [3:0] clamp_len(input logic [3:0] len);
    return (len > MATCH_LEN) ? MATCH_LEN : len;
  endfunction

endpackage

// ===== hw/rtl/command_frame_decimal_parser.sv =====
// Top level of the command frame decimal parser.
// Usage:
//   The input channel (in_valid, in_ready, rx_byte, frame_end) takes one frame
//   byte per word; frame_end marks the last byte of a frame.
//   The output channel (out_valid, out_ready, event_kind, value_milli) gives at
//   most one event per frame: a set-value event with the number in thousandths,
//   or a toggle command event with a value of zero.
//   The configuration port (cfg_write, cfg_index, cfg_data) writes the prefix,
//   the command and their lengths; write it only while no frame is in flight.
// Timing:
//   One word is taken every cycle while in_ready is high. A byte waits in the
//   input register and is then parsed in a single pass into the result
//   register, from which the event of a frame is given after its last byte.
//   The rate is set by the one-byte parse step, which is combinational.
// Reset and stalls:
//   Reset clears the frame state, the configuration and both pipeline valids.
//   While the receiver holds out_ready low with an event pending, the input
//   register holds one more word, after which in_ready drops.
`timescale 1ns / 1ps
`include "command_frame_decimal_parser_assert.svh"
module command_frame_decimal_parser (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             rx_byte,
  input  logic                                   frame_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   event_kind,
  output logic signed [cfdp_pkg::VALUE_BITS-1:0] value_milli,
  input  logic                                   cfg_write,
  input  logic [1:0]                             cfg_index,
  input  logic [cfdp_pkg::CFG_W-1:0]             cfg_data
);

  logic [cfdp_pkg::CFG_W-1:0] value_prefix;
  logic [3:0]                 value_prefix_len;
  logic [cfdp_pkg::CFG_W-1:0] toggle_command;
  logic [3:0]                 toggle_command_len;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       advance;

  cfdp_pkg::step_t  step;
  cfdp_pkg::match_t match;
  cfdp_pkg::parse_t number;

  logic                                   emit_value;
  logic                                   emit_toggle;
  logic signed [cfdp_pkg::VALUE_BITS-1:0] signed_value;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      value_prefix       <= '0;
      value_prefix_len   <= '0;
      toggle_command     <= '0;
      toggle_command_len <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        cfdp_pkg::REG_VALUE_PREFIX:       value_prefix       <= cfg_data;
        cfdp_pkg::REG_VALUE_PREFIX_LEN:   value_prefix_len   <= cfg_data[3:0];
        cfdp_pkg::REG_TOGGLE_COMMAND:     toggle_command     <= cfg_data;
        cfdp_pkg::REG_TOGGLE_COMMAND_LEN: toggle_command_len <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // The held byte moves on when the result register is free or being emptied.
  assign advance  = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
      last_q <= frame_end;
    end
  end

  assign step.fire = advance;
  assign step.last = last_q;
  assign step.data = byte_q;

  cfdp_match u_match (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .value_prefix       (value_prefix),
    .value_prefix_len   (value_prefix_len),
    .toggle_command     (toggle_command),
    .toggle_command_len (toggle_command_len),
    .match              (match)
  );

  cfdp_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .parse_en (match.parse_en),
    .number   (number)
  );

  // Event selection at the last byte; a value event wins over the toggle.
  assign emit_value   = last_q && match.value_ok && number.digit_seen;
  assign emit_toggle  = last_q && !emit_value && match.toggle_ok;
  assign signed_value = number.negative ?
                        -$signed({1'b0, number.magnitude}) :
                        $signed({1'b0, number.magnitude});

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit_value || emit_toggle;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (emit_value || emit_toggle)) begin
      event_kind  <= emit_value ? cfdp_pkg::KIND_VALUE : cfdp_pkg::KIND_TOGGLE;
      value_milli <= emit_value ? signed_value : '0;
    end
  end

  // Checks on event contents and pipeline control.
  `CFDP_ASSERT_SAME(a_toggle_zero, out_valid && event_kind == cfdp_pkg::KIND_TOGGLE, value_milli == '0)
  `CFDP_ASSERT_SAME(a_value_range, out_valid && event_kind == cfdp_pkg::KIND_VALUE, value_milli != cfdp_pkg::VALUE_MIN)
  `CFDP_ASSERT_SAME(a_stall_cause, !in_ready, in_valid_q && out_valid && !out_ready)
  `CFDP_ASSERT_NEXT(a_event_on_last, advance && !last_q, !out_valid)

endmodule

// ===== hw/rtl/cfdp_match.sv =====
// Byte position counter and prefix / command comparison for each frame.
`timescale 1ns / 1ps
module cfdp_match (
  input  logic                       clk,
  input  logic                       rst,
  input  cfdp_pkg::step_t            step,
  input  logic [cfdp_pkg::CFG_W-1:0] value_prefix,
  input  logic [3:0]                 value_prefix_len,
  input  logic [cfdp_pkg::CFG_W-1:0] toggle_command,
  input  logic [3:0]                 toggle_command_len,
  output cfdp_pkg::match_t           match
);

  logic [3:0] byte_position;
  logic       prefix_matching;
  logic       command_matching;

  logic [3:0] byte_position_next;
  logic       prefix_matching_next;
  logic       command_matching_next;

  logic [3:0]                    plen;
  logic [3:0]                    clen;
  logic [cfdp_pkg::IDX_W-1:0]    idx;
  logic [7:0]                    prefix_byte;
  logic [7:0]                    command_byte;
  logic [4:0]                    length;

  assign plen         = cfdp_pkg::clamp_len(value_prefix_len);
  assign clen         = cfdp_pkg::clamp_len(toggle_command_len);
  assign idx          = byte_position[cfdp_pkg::IDX_W-1:0];
  assign prefix_byte  = value_prefix[8*idx +: 8];
  assign command_byte = toggle_command[8*idx +: 8];
  assign length       = {1'b0, byte_position} + 5'd1;

  // Compare the current byte against both patterns.
  always_comb begin
    prefix_matching_next = prefix_matching;
    if (byte_position < plen && prefix_byte != step.data) begin
      prefix_matching_next = 1'b0;
    end
    command_matching_next = command_matching && (byte_position < clen) &&
                            (command_byte == step.data);
    byte_position_next = (byte_position == 4'hF) ? byte_position : byte_position + 4'd1;
  end

  // Bytes after a still matching prefix feed the number parser.
  assign match.parse_en  = (byte_position >= plen) && (plen != 4'd0) && prefix_matching;
  assign match.value_ok  = (plen != 4'd0) && prefix_matching_next &&
                           (length > {1'b0, plen});
  assign match.toggle_ok = (clen != 4'd0) && command_matching_next &&
                           (length == {1'b0, clen});

  // Frame state returns to its start after the last word of a frame.
  always_ff @(posedge clk) begin
    if (rst || (step.fire && step.last)) begin
      byte_position    <= 4'd0;
      prefix_matching  <= 1'b1;
      command_matching <= 1'b1;
    end else if (step.fire) begin
      byte_position    <= byte_position_next;
      prefix_matching  <= prefix_matching_next;
      command_matching <= command_matching_next;
    end
  end

endmodule

// ===== hw/rtl/cfdp_parse.sv =====
// Signed decimal parser that accumulates a saturating fixed point magnitude.
`timescale 1ns / 1ps
module cfdp_parse (
  input  logic             clk,
  input  logic             rst,
  input  cfdp_pkg::step_t  step,
  input  logic             parse_en,
  output cfdp_pkg::parse_t number
);

  typedef enum logic [1:0] {PH_SIGN, PH_INT, PH_FRAC, PH_DONE} phase_t;

  phase_t                       phase;
  logic                         negative_sign;
  logic                         digit_seen;
  logic [cfdp_pkg::MAG_W-1:0]   magnitude;
  logic [cfdp_pkg::FC_W-1:0]    fraction_count;

  phase_t                       phase_next;
  logic                         negative_sign_next;
  logic                         digit_seen_next;
  logic [cfdp_pkg::MAG_W-1:0]   magnitude_next;
  logic [cfdp_pkg::FC_W-1:0]    fraction_count_next;

  logic                         is_digit;
  logic [3:0]                   digit;
  logic                         frac_mode;
  logic                         frac_room;
  logic [cfdp_pkg::W10_W-1:0]   weight;
  logic [cfdp_pkg::SUM_W-1:0]   base;
  logic [cfdp_pkg::SUM_W-1:0]   prod;
  logic [cfdp_pkg::SUM_W-1:0]   sum;
  logic [cfdp_pkg::MAG_W-1:0]   sat;

  assign is_digit  = (step.data >= cfdp_pkg::CHAR_ZERO) && (step.data <= cfdp_pkg::CHAR_NINE);
  assign digit     = 4'(step.data - cfdp_pkg::CHAR_ZERO);
  assign frac_mode = (phase == PH_FRAC);
  assign frac_room = (int'(fraction_count) < cfdp_pkg::FRACTION_DIGITS);

  // Integer digits scale the magnitude by ten; fraction digits add at their weight.
  assign weight = frac_mode ?
                  cfdp_pkg::pow10(cfdp_pkg::FRACTION_DIGITS - 1 - int'(fraction_count)) :
                  cfdp_pkg::pow10(cfdp_pkg::FRACTION_DIGITS);
  assign base   = frac_mode ? cfdp_pkg::SUM_W'(magnitude) :
                  (cfdp_pkg::SUM_W'(magnitude) << 3) + (cfdp_pkg::SUM_W'(magnitude) << 1);
  assign prod   = cfdp_pkg::SUM_W'(digit) * cfdp_pkg::SUM_W'(weight);
  assign sum    = base + prod;
  assign sat    = (|sum[cfdp_pkg::SUM_W-1:cfdp_pkg::MAG_W]) ? {cfdp_pkg::MAG_W{1'b1}} :
                  sum[cfdp_pkg::MAG_W-1:0];

  // Next parse state for the current byte.
  always_comb begin
    phase_next          = phase;
    negative_sign_next  = negative_sign;
    digit_seen_next     = digit_seen;
    magnitude_next      = magnitude;
    fraction_count_next = fraction_count;
    if (step.fire && parse_en) begin
      case (phase)
        PH_SIGN, PH_INT: begin
          if (phase == PH_SIGN && step.data == cfdp_pkg::CHAR_MINUS) begin
            negative_sign_next = 1'b1;
            phase_next         = PH_INT;
          end else if (is_digit) begin
            magnitude_next  = sat;
            digit_seen_next = 1'b1;
            phase_next      = PH_INT;
          end else if (step.data == cfdp_pkg::CHAR_DOT) begin
            phase_next = PH_FRAC;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            if (frac_room) begin
              magnitude_next      = sat;
              fraction_count_next = cfdp_pkg::FC_W'(fraction_count + 1'b1);
            end
            digit_seen_next = 1'b1;
          end else begin
            phase_next = PH_DONE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  assign number.digit_seen = digit_seen_next;
  assign number.negative   = negative_sign_next;
  assign number.magnitude  = magnitude_next;

  // Parse state, cleared after the last word of every frame.
  always_ff @(posedge clk) begin
    if (rst || (step.fire && step.last)) begin
      phase          <= PH_SIGN;
      negative_sign  <= 1'b0;
      digit_seen     <= 1'b0;
      magnitude      <= '0;
      fraction_count <= '0;
    end else begin
      phase          <= phase_next;
      negative_sign  <= negative_sign_next;
      digit_seen     <= digit_seen_next;
      magnitude      <= magnitude_next;
      fraction_count <= fraction_count_next;
    end
  end

endmodule
